/* rtl/core/s2cd_pkg.sv */
// s2cd_pkg: constants and helpers for the seconds-to-calendar-date pipeline.
// No dependencies; imported by seconds_to_calendar_date_top and its testbench.
package s2cd_pkg;

  // Seconds from 1970-01-01 to 2000-01-01
  localparam logic [31:0] SECS_TO_2000 = 32'd946684800;

  // Reciprocal constants: floor(x * M >> K) == x / d over the ranges used
  localparam logic [30:0] RECIP_15     = 31'd1145324613;  // 2^34 / 15, rounded up
  localparam int          RECIP_15_SH  = 34;
  localparam logic [18:0] RECIP_3      = 19'd349526;      // 2^20 / 3, rounded up
  localparam int          RECIP_3_SH   = 20;
  localparam logic [15:0] RECIP_1461   = 16'd45934;       // 2^26 / 1461, rounded up
  localparam int          RECIP_1461_SH = 26;

  localparam logic [15:0] DAYS_PER_QUAD = 16'd1461;
  localparam logic [10:0] YEAR1_START   = 11'd366;
  localparam logic [10:0] YEAR2_START   = 11'd731;
  localparam logic [10:0] YEAR3_START   = 11'd1096;

  localparam logic [7:0] YEAR_BASE = 8'd100;

  localparam logic [3:0] LAST_MONTH = 4'd11;

  // First day-of-year (0 based) of each month; leap years shift March on by one
  function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    base = 9'd0;
    case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mon >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

/* rtl/core/seconds_to_calendar_date_top.sv */
// seconds_to_calendar_date_top: ten-stage pipeline turning a seconds count since
// 1970 into calendar fields from year 2000. Uses s2cd_pkg.

// Converts a 32-bit seconds count since 1970-01-01 00:00:00 into year (minus 1900),
// month 0..11, day 1..31, hour, minute and second. Every fourth year from 2000 is
// leap, with no century rule. Counts before 2000 set out_before_epoch and zero all
// other fields. The pipeline takes one transfer per cycle while it is not stalled;
// out_valid rises once the transfer has passed through every stage register. The
// single global stage enable holds the whole pipe while out_stall is high and a
// result is waiting. Divisions by 60, 60 and 24 are reciprocal multiplies, each in
// its own stage, followed by a 4-year split, a year-in-quad compare and a month
// lookup.
module seconds_to_calendar_date_top
  import s2cd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_seconds_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_before_epoch,
  output logic [7:0]  out_year_since_1900,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour_of_day,
  output logic [5:0]  out_minute_of_hour,
  output logic [5:0]  out_second_of_minute
);

  localparam int NUM_STAGES = 10;

  logic                  adv;
  logic [NUM_STAGES-1:0] vld_r;

  // stage 1
  logic        bef1_r;
  logic [31:0] t1_r;
  // stage 2
  logic        bef2_r;
  logic [31:0] t2_r;
  logic [60:0] prod1_r;
  // stage 3
  logic        bef3_r;
  logic [5:0]  sec3_r;
  logic [25:0] q1_3_r;
  logic [54:0] prod2_r;
  // stage 4
  logic        bef4_r;
  logic [5:0]  sec4_r, min4_r;
  logic [19:0] q2_4_r;
  logic [35:0] prod3_r;
  // stage 5
  logic        bef5_r;
  logic [5:0]  sec5_r, min5_r;
  logic [4:0]  hr5_r;
  logic [15:0] days5_r;
  // stage 6
  logic        bef6_r;
  logic [5:0]  sec6_r, min6_r;
  logic [4:0]  hr6_r;
  logic [15:0] days6_r;
  logic [31:0] prod4_r;
  // stage 7
  logic        bef7_r;
  logic [5:0]  sec7_r, min7_r;
  logic [4:0]  hr7_r;
  logic [4:0]  quad7_r;
  logic [10:0] rem7_r;
  // stage 8
  logic        bef8_r;
  logic [5:0]  sec8_r, min8_r;
  logic [4:0]  hr8_r;
  logic [6:0]  yoff8_r;
  logic        leap8_r;
  logic [8:0]  doy8_r;
  // stage 9
  logic        bef9_r;
  logic [5:0]  sec9_r, min9_r;
  logic [4:0]  hr9_r;
  logic [6:0]  yoff9_r;
  logic        leap9_r;
  logic [8:0]  doy9_r;
  logic [3:0]  mon9_r;
  // stage 10 (output)
  logic        bef10_r;
  logic [7:0]  year10_r;
  logic [3:0]  mon10_r;
  logic [4:0]  day10_r;
  logic [4:0]  hr10_r;
  logic [5:0]  min10_r, sec10_r;

  // combinational next values
  logic        bef1_nxt;
  logic [31:0] t1_nxt;
  logic [60:0] prod1_nxt;
  logic [25:0] q1_nxt;
  logic [5:0]  sec3_nxt;
  logic [54:0] prod2_nxt;
  logic [19:0] q2_nxt;
  logic [5:0]  min4_nxt;
  logic [35:0] prod3_nxt;
  logic [15:0] days5_nxt;
  logic [4:0]  hr5_nxt;
  logic [31:0] prod4_nxt;
  logic [4:0]  quad7_nxt;
  logic [10:0] rem7_nxt;
  logic [1:0]  yq8_nxt;
  logic [10:0] ybase8_nxt;
  logic [6:0]  yoff8_nxt;
  logic [8:0]  doy8_nxt;
  logic [3:0]  mon9_nxt;
  logic [8:0]  mstart10_nxt;
  logic [4:0]  day10_nxt;

  // whole pipe moves unless a finished result is held
  assign adv      = !(vld_r[NUM_STAGES-1] && out_stall);
  assign in_stall = !adv;

  // stage 1: epoch check and offset
  assign bef1_nxt = in_seconds_count < SECS_TO_2000;
  assign t1_nxt   = in_seconds_count - SECS_TO_2000;

  // stage 2: t / 60 as (t >> 2) / 15
  assign prod1_nxt = 61'(t1_r[31:2] * RECIP_15);

  // stage 3: seconds, then minutes count / 60
  assign q1_nxt    = prod1_r[RECIP_15_SH +: 26];
  assign sec3_nxt  = 6'(t2_r - ({q1_nxt, 6'b0} - {q1_nxt, 2'b0}));
  assign prod2_nxt = 55'(q1_nxt[25:2] * RECIP_15);

  // stage 4: minutes, then hours count / 24 as (h >> 3) / 3
  assign q2_nxt    = prod2_r[RECIP_15_SH +: 20];
  assign min4_nxt  = 6'(q1_3_r - ({q2_nxt, 6'b0} - {q2_nxt, 2'b0}));
  assign prod3_nxt = 36'(q2_nxt[19:3] * RECIP_3);

  // stage 5: days and hour
  assign days5_nxt = prod3_r[RECIP_3_SH +: 16];
  assign hr5_nxt   = 5'(q2_4_r - ({days5_nxt, 4'b0} + {1'b0, days5_nxt, 3'b0}));

  // stage 6: 4-year quads
  assign prod4_nxt = 32'(days5_r * RECIP_1461);

  // stage 7: quad index and day within quad
  assign quad7_nxt = prod4_r[RECIP_1461_SH +: 5];
  assign rem7_nxt  = 11'(days6_r - 16'({11'd0, quad7_nxt} * DAYS_PER_QUAD));

  // stage 8: year within quad; first year of each quad is leap
  always_comb begin
    yq8_nxt    = 2'd0;
    ybase8_nxt = 11'd0;
    if (rem7_r >= YEAR3_START) begin
      yq8_nxt    = 2'd3;
      ybase8_nxt = YEAR3_START;
    end else if (rem7_r >= YEAR2_START) begin
      yq8_nxt    = 2'd2;
      ybase8_nxt = YEAR2_START;
    end else if (rem7_r >= YEAR1_START) begin
      yq8_nxt    = 2'd1;
      ybase8_nxt = YEAR1_START;
    end
  end
  assign yoff8_nxt = {quad7_r, yq8_nxt};
  assign doy8_nxt  = 9'(rem7_r - ybase8_nxt);

  // stage 9: month by compare against month starts
  always_comb begin
    mon9_nxt = 4'd0;
    for (int k = 1; k <= int'(LAST_MONTH); k++) begin
      if (doy8_r >= month_start(4'(k), leap8_r)) begin
        mon9_nxt = 4'(k);
      end
    end
  end

  // stage 10: day of month
  assign mstart10_nxt = month_start(mon9_r, leap9_r);
  assign day10_nxt    = 5'(doy9_r - mstart10_nxt + 9'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bef1_r  <= bef1_nxt;
      t1_r    <= t1_nxt;

      bef2_r  <= bef1_r;
      t2_r    <= t1_r;
      prod1_r <= prod1_nxt;

      bef3_r  <= bef2_r;
      sec3_r  <= sec3_nxt;
      q1_3_r  <= q1_nxt;
      prod2_r <= prod2_nxt;

      bef4_r  <= bef3_r;
      sec4_r  <= sec3_r;
      min4_r  <= min4_nxt;
      q2_4_r  <= q2_nxt;
      prod3_r <= prod3_nxt;

      bef5_r  <= bef4_r;
      sec5_r  <= sec4_r;
      min5_r  <= min4_r;
      hr5_r   <= hr5_nxt;
      days5_r <= days5_nxt;

      bef6_r  <= bef5_r;
      sec6_r  <= sec5_r;
      min6_r  <= min5_r;
      hr6_r   <= hr5_r;
      days6_r <= days5_r;
      prod4_r <= prod4_nxt;

      bef7_r  <= bef6_r;
      sec7_r  <= sec6_r;
      min7_r  <= min6_r;
      hr7_r   <= hr6_r;
      quad7_r <= quad7_nxt;
      rem7_r  <= rem7_nxt;

      bef8_r  <= bef7_r;
      sec8_r  <= sec7_r;
      min8_r  <= min7_r;
      hr8_r   <= hr7_r;
      yoff8_r <= yoff8_nxt;
      leap8_r <= (yq8_nxt == 2'd0);
      doy8_r  <= doy8_nxt;

      bef9_r  <= bef8_r;
      sec9_r  <= sec8_r;
      min9_r  <= min8_r;
      hr9_r   <= hr8_r;
      yoff9_r <= yoff8_r;
      leap9_r <= leap8_r;
      doy9_r  <= doy8_r;
      mon9_r  <= mon9_nxt;

      // counts before 2000 report all-zero fields
      bef10_r  <= bef9_r;
      year10_r <= bef9_r ? 8'd0 : ({1'b0, yoff9_r} + YEAR_BASE);
      mon10_r  <= bef9_r ? 4'd0 : mon9_r;
      day10_r  <= bef9_r ? 5'd0 : day10_nxt;
      hr10_r   <= bef9_r ? 5'd0 : hr9_r;
      min10_r  <= bef9_r ? 6'd0 : min9_r;
      sec10_r  <= bef9_r ? 6'd0 : sec9_r;
    end
  end

  assign out_valid            = vld_r[NUM_STAGES-1];
  assign out_before_epoch     = bef10_r;
  assign out_year_since_1900  = year10_r;
  assign out_month_index      = mon10_r;
  assign out_day_of_month     = day10_r;
  assign out_hour_of_day      = hr10_r;
  assign out_minute_of_hour   = min10_r;
  assign out_second_of_minute = sec10_r;

endmodule

/* tb/sv/seconds_to_calendar_date_top_tb.sv */
// Self-checking testbench for seconds_to_calendar_date_top: drives seconds counts
// with bursty valid and random result stall, and checks every calendar field.
// Depends on s2cd_pkg and the seconds_to_calendar_date_top RTL.
`timescale 1ns / 1ps

module seconds_to_calendar_date_top_tb
  import s2cd_pkg::*;
;

  localparam int RANDOM_ITEMS = 1500;
  localparam int PIPE_LATENCY = 10;
  localparam longint unsigned SECS_PER_DAY = 86400;
  localparam longint unsigned MAX_COUNT = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic       before_epoch;
    logic [7:0] year_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } cal_date_t;

  function automatic int unsigned days_in_month(int unsigned mon, bit leap);
    int unsigned len;
    case (mon)
      1:       len = leap ? 29 : 28;
      3, 5, 8, 10: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  class calendar_scoreboard;
    cal_date_t   pending_dates[$];
    int unsigned mismatches;
    int unsigned dates_checked;
    int unsigned early_counts;

    function new();
      mismatches    = 0;
      dates_checked = 0;
      early_counts  = 0;
    endfunction

    // Every fourth year from 2000 is leap, no century rule
    function cal_date_t to_calendar(logic [31:0] secs);
      cal_date_t       d;
      longint unsigned rest;
      longint unsigned days;
      int unsigned     yoff;
      int unsigned     mon;
      int unsigned     ylen;
      bit              leap;
      d = '0;
      if (secs < SECS_TO_2000) begin
        d.before_epoch = 1'b1;
        return d;
      end
      rest = longint'(secs) - longint'(SECS_TO_2000);
      d.second_of_minute = 6'(rest % 60);
      rest = rest / 60;
      d.minute_of_hour = 6'(rest % 60);
      rest = rest / 60;
      d.hour_of_day = 5'(rest % 24);
      days = rest / 24;
      leap = 1'b1;
      for (yoff = 0; yoff < 255; yoff++) begin
        leap = (yoff % 4) == 0;
        ylen = leap ? 366 : 365;
        if (days < ylen) break;
        days -= ylen;
      end
      // December takes whatever is left
      for (mon = 0; mon < 11; mon++) begin
        if (days < days_in_month(mon, leap)) break;
        days -= days_in_month(mon, leap);
      end
      d.year_since_1900 = 8'(yoff + 100);
      d.month_index     = 4'(mon);
      d.day_of_month    = 5'(days + 1);
      return d;
    endfunction

    function void note_input(logic [31:0] secs);
      if (secs < SECS_TO_2000) early_counts++;
      pending_dates.push_back(to_calendar(secs));
    endfunction

    function void check_result(cal_date_t got);
      cal_date_t want;
      if (pending_dates.size() == 0) begin
        $error("result transfer with nothing pending");
        mismatches++;
        return;
      end
      want = pending_dates.pop_front();
      dates_checked++;
      if (got.before_epoch !== want.before_epoch) begin
        $error("before_epoch: expected %0d, got %0d", want.before_epoch, got.before_epoch);
        mismatches++;
      end
      if (got.year_since_1900 !== want.year_since_1900) begin
        $error("year_since_1900: expected %0d, got %0d",
               want.year_since_1900, got.year_since_1900);
        mismatches++;
      end
      if (got.month_index !== want.month_index) begin
        $error("month_index: expected %0d, got %0d", want.month_index, got.month_index);
        mismatches++;
      end
      if (got.day_of_month !== want.day_of_month) begin
        $error("day_of_month: expected %0d, got %0d", want.day_of_month, got.day_of_month);
        mismatches++;
      end
      if (got.hour_of_day !== want.hour_of_day) begin
        $error("hour_of_day: expected %0d, got %0d", want.hour_of_day, got.hour_of_day);
        mismatches++;
      end
      if (got.minute_of_hour !== want.minute_of_hour) begin
        $error("minute_of_hour: expected %0d, got %0d",
               want.minute_of_hour, got.minute_of_hour);
        mismatches++;
      end
      if (got.second_of_minute !== want.second_of_minute) begin
        $error("second_of_minute: expected %0d, got %0d",
               want.second_of_minute, got.second_of_minute);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_dates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_seconds_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_before_epoch;
  logic [7:0]  out_year_since_1900;
  logic [3:0]  out_month_index;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour_of_day;
  logic [5:0]  out_minute_of_hour;
  logic [5:0]  out_second_of_minute;

  calendar_scoreboard sb = new();

  seconds_to_calendar_date_top uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_seconds_count     (in_seconds_count),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_before_epoch     (out_before_epoch),
    .out_year_since_1900  (out_year_since_1900),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute)
  );

  always #5 clk = ~clk;

  // Result monitor: values seen here are the ones present before this edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_before_epoch, out_year_since_1900, out_month_index,
                       out_day_of_month, out_hour_of_day, out_minute_of_hour,
                       out_second_of_minute});
    end
  end

  // Receiver stall: switches between free-running, coin-flip, periodic and heavy
  int unsigned stall_mode = 0;
  int unsigned stall_mode_left = 0;
  int unsigned stall_cycle = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_mode_left == 0) begin
        stall_mode      <= $urandom_range(0, 3);
        stall_mode_left <= $urandom_range(40, 300);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= $urandom_range(0, 1) == 1;
        2:       out_stall <= (stall_cycle % 5) < 2;
        default: out_stall <= $urandom_range(0, 15) < 13;
      endcase
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happened
  task automatic send_count(input logic [31:0] secs);
    in_valid         <= 1'b1;
    in_seconds_count <= secs;
    do @(posedge clk); while (in_stall);
    sb.note_input(secs);
  endtask

  task automatic idle_input(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Start of a random month, nudged to the second before, the first or last
  // second of that day, or somewhere inside it
  function automatic logic [31:0] month_edge_count();
    longint unsigned days;
    longint unsigned secs;
    int unsigned     yoff;
    int unsigned     mon;
    int unsigned     y;
    int unsigned     m;
    yoff = $urandom_range(0, 106);
    mon  = $urandom_range(0, 11);
    days = 0;
    for (y = 0; y < yoff; y++) days += ((y % 4) == 0) ? 366 : 365;
    for (m = 0; m < mon; m++) days += days_in_month(m, (yoff % 4) == 0);
    secs = longint'(SECS_TO_2000) + days * SECS_PER_DAY;
    case ($urandom_range(0, 3))
      0:       secs = secs - 1;
      1:       secs = secs + SECS_PER_DAY - 1;
      2:       secs = secs + $urandom_range(0, 86399);
      default: secs = secs;
    endcase
    if (secs > MAX_COUNT) return $urandom;
    return 32'(secs);
  endfunction

  function automatic logic [31:0] random_count();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return $urandom;
    if (pick < 65) return $urandom_range(SECS_TO_2000, 32'hFFFF_FFFF);
    return month_edge_count();
  endfunction

  logic [31:0] directed_counts[] = '{
    32'd0, 32'd1, 32'd946684799, 32'd946684800, 32'd946684801,
    32'd946771199,   // last second of 2000-01-01
    32'd951782400,   // 2000-02-29
    32'd951868800,   // 2000-03-01
    32'd978307199,   // 2000-12-31 23:59:59
    32'd978307200,   // 2001-01-01
    32'd983318400,   // 2001-02-28, non-leap
    32'd983404800,   // 2001-03-01
    32'd1072915199,  // end of 2003
    32'd1072915200,  // start of 2004, leap
    32'd2147483647, 32'd2147483648,
    32'd4107542400,  // 2100-02-29, leap here with no century rule
    32'd4107628800,  // 2100-03-01
    32'h5555_5555, 32'hAAAA_AAAA,
    32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  int unsigned items_sent = 0;
  int unsigned burst_len;
  int unsigned drain_cycles;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_counts[i]) begin
      send_count(directed_counts[i]);
      items_sent++;
      idle_input($urandom_range(0, 1) == 1 ? $urandom_range(1, 4) : 0);
    end

    while (items_sent < directed_counts.size() + RANDOM_ITEMS) begin
      burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
      repeat (burst_len) begin
        send_count(random_count());
        items_sent++;
      end
      case ($urandom_range(0, 5))
        0, 1:    idle_input(0);
        5:       idle_input($urandom_range(15, 40));
        default: idle_input($urandom_range(1, 8));
      endcase
    end
    in_valid <= 1'b0;

    drain_cycles = 0;
    while (sb.outstanding() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (PIPE_LATENCY * 2) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d expected dates never arrived", sb.outstanding());
      sb.mismatches++;
    end

    $display("Sent %0d seconds counts (%0d before 2000), checked %0d calendar dates.",
             items_sent, sb.early_counts, sb.dates_checked);
    $display("Covered leap and month edges out to 2106 under bursty input and output stall.");
    if (sb.mismatches == 0) begin
      $display("seconds_to_calendar_date_top_tb: done, clean");
    end else begin
      $display("seconds_to_calendar_date_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("seconds_to_calendar_date_top_tb: done, errors");
    $finish;
  end

endmodule
